// ----- src/zpip_pkg.sv -----
// Shared types, constants and helpers for the zoned point-in-polygon block.
package zpip_pkg;

  localparam int MAX_AREAS    = 4;
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 32;
  localparam int MIN_VERTICES = 3;
  localparam int QUEUE_DEPTH  = 2;

  // fixed port widths
  localparam int REQ_W      = 2;
  localparam int IN_AREA_W  = 2;
  localparam int IN_VTX_W   = 6;
  localparam int IN_CNT_W   = 7;
  localparam int IN_COORD_W = 32;
  localparam int WIND_W     = 7;
  localparam int STATUS_W   = 2;
  localparam int HIT_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;
  localparam int CFG_CNT_W  = 3;

  localparam int KIND_SLOTS    = MAX_AREAS * MAX_VERTICES;
  localparam int VSTORE_DEPTH  = 2 * KIND_SLOTS;
  localparam int CNT_DEPTH     = 2 * MAX_AREAS;
  localparam int VADDR_W       = $clog2(VSTORE_DEPTH);
  localparam int CIDX_W        = $clog2(CNT_DEPTH);
  localparam int AREA_W        = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int AREA_CNT_W    = $clog2(MAX_AREAS + 1);
  localparam int VTX_W         = $clog2(MAX_VERTICES);
  localparam int VCNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int WN_W          = VCNT_W + 1;
  localparam int DIFF_W        = COORD_BITS + 1;
  localparam int PROD_W        = 2 * COORD_BITS;
  localparam int WIND_MAX      = 2 ** (WIND_W - 1) - 1;
  localparam int WIND_MIN      = -(2 ** (WIND_W - 1));

  localparam logic [REQ_W-1:0] REQ_VERTEX = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COUNT  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIRED_EN   = 2'd2;

  localparam logic KIND_MAIN = 1'b0;
  localparam logic KIND_EXCL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OUTSIDE = 2'd0,
    ST_MAIN    = 2'd1,
    ST_EXCL    = 2'd2,
    ST_WIRED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_VWRITE,
    OP_CWRITE,
    OP_QUERY
  } op_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AREA,
    BK_EDGE,
    BK_DRAIN,
    BK_DONE
  } back_state_t;

  typedef struct packed {
    logic [CFG_CNT_W-1:0] main_count;
    logic [CFG_CNT_W-1:0] excl_count;
    logic                 wired_en;
  } cfg_t;

  typedef struct packed {
    op_t                           op;
    logic [VADDR_W-1:0]            vaddr;
    logic [CIDX_W-1:0]             cidx;
    logic [VCNT_W-1:0]             cnt;
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  function automatic logic [VADDR_W-1:0] vaddr_of(input logic kind,
                                                  input logic [AREA_W-1:0] area,
                                                  input logic [VTX_W-1:0] vtx);
    vaddr_of = VADDR_W'(kind) * VADDR_W'(KIND_SLOTS)
             + VADDR_W'(area) * VADDR_W'(MAX_VERTICES)
             + VADDR_W'(vtx);
  endfunction

  function automatic logic [CIDX_W-1:0] cidx_of(input logic kind,
                                                input logic [AREA_W-1:0] area);
    cidx_of = CIDX_W'(kind) * CIDX_W'(MAX_AREAS) + CIDX_W'(area);
  endfunction

endpackage

// ----- src/zoned_point_in_polygon.sv -----
// Zoned point-in-polygon: top level with configuration registers.
// Writes: one per cycle while the walker is idle, each queued and then retired when the walker pops it.
// Queries walk one edge per cycle through the 4-stage edge pipeline, draining it after
// each tested area; the walk covers up to eight 64-vertex areas, one query at a time.
// Synchronous active-high reset clears counts, registers, queue and output valid.
module zoned_point_in_polygon (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [zpip_pkg::REQ_W-1:0]             req_type,
  input  logic                                   area_kind,
  input  logic [zpip_pkg::IN_AREA_W-1:0]         area_index,
  input  logic [zpip_pkg::IN_VTX_W-1:0]          vertex_index,
  input  logic [zpip_pkg::IN_CNT_W-1:0]          vertex_count,
  input  logic signed [zpip_pkg::IN_COORD_W-1:0] coord_x,
  input  logic signed [zpip_pkg::IN_COORD_W-1:0] coord_y,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [zpip_pkg::WIND_W-1:0]     winding,
  output logic [zpip_pkg::STATUS_W-1:0]          status,
  output logic [zpip_pkg::HIT_W-1:0]             hit_area,
  input  logic                                   cfg_write_en,
  input  logic [zpip_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [zpip_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import zpip_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd, head_cmd;
  logic push, pop, q_full, q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_MAIN_COUNT: cfg.main_count <= cfg_data[CFG_CNT_W-1:0];
        CFG_EXCL_COUNT: cfg.excl_count <= cfg_data[CFG_CNT_W-1:0];
        CFG_WIRED_EN:   cfg.wired_en   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  zpip_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .area_kind    (area_kind),
    .area_index   (area_index),
    .vertex_index (vertex_index),
    .vertex_count (vertex_count),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .q_full       (q_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  zpip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .head      (head_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  zpip_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (head_cmd),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .winding   (winding),
    .status    (status),
    .hit_area  (hit_area)
  );

endmodule

// ----- src/zpip_front.sv -----
// Input decode: classifies each transaction and builds a queue command.
module zpip_front (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [zpip_pkg::REQ_W-1:0]          req_type,
  input  logic                                area_kind,
  input  logic [zpip_pkg::IN_AREA_W-1:0]      area_index,
  input  logic [zpip_pkg::IN_VTX_W-1:0]       vertex_index,
  input  logic [zpip_pkg::IN_CNT_W-1:0]       vertex_count,
  input  logic signed [zpip_pkg::IN_COORD_W-1:0] coord_x,
  input  logic signed [zpip_pkg::IN_COORD_W-1:0] coord_y,
  input  logic                                q_full,
  output logic                                push,
  output zpip_pkg::cmd_t                      cmd
);
  import zpip_pkg::*;

  logic area_ok;
  logic vtx_ok;
  logic keep;

  assign in_ready = !q_full;
  assign area_ok  = 32'(area_index) < MAX_AREAS;
  assign vtx_ok   = 32'(vertex_index) < MAX_VERTICES;

  always_comb begin
    keep      = 1'b0;
    cmd.op    = OP_QUERY;
    cmd.vaddr = vaddr_of(area_kind, AREA_W'(area_index), VTX_W'(vertex_index));
    cmd.cidx  = cidx_of(area_kind, AREA_W'(area_index));
    // counts saturate at the vertex capacity
    cmd.cnt   = (32'(vertex_count) > MAX_VERTICES) ? VCNT_W'(MAX_VERTICES)
                                                   : VCNT_W'(vertex_count);
    cmd.x     = coord_x[COORD_BITS-1:0];
    cmd.y     = coord_y[COORD_BITS-1:0];
    case (req_type)
      REQ_VERTEX: begin
        keep   = area_ok && vtx_ok;
        cmd.op = OP_VWRITE;
      end
      REQ_COUNT: begin
        keep   = area_ok;
        cmd.op = OP_CWRITE;
      end
      REQ_QUERY: begin
        keep   = 1'b1;
        cmd.op = OP_QUERY;
      end
      default: begin
        keep   = 1'b0;
        cmd.op = OP_QUERY;
      end
    endcase
  end

  assign push = in_valid && in_ready && keep;

endmodule

// ----- src/zpip_queue.sv -----
// Small command queue between decode and the area walker.
module zpip_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  zpip_pkg::cmd_t push_data,
  input  logic           pop,
  output zpip_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import zpip_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QUEUE_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QUEUE_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- src/zpip_back.sv -----
// Area walker: executes stores and runs the winding-number scan per query.
module zpip_back (
  input  logic                               clk,
  input  logic                               rst,
  input  zpip_pkg::cfg_t                     cfg,
  input  zpip_pkg::cmd_t                     cmd,
  input  logic                               q_empty,
  output logic                               pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [zpip_pkg::WIND_W-1:0] winding,
  output logic [zpip_pkg::STATUS_W-1:0]      status,
  output logic [zpip_pkg::HIT_W-1:0]         hit_area
);
  import zpip_pkg::*;

  function automatic logic [COORD_BITS-1:0] mag_of(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = -d;
    mag_of = d[DIFF_W-1] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
  endfunction

  back_state_t state, state_next;

  // sequencer
  logic signed [COORD_BITS-1:0] qx, qy;
  logic                         kind_r;
  logic [AREA_CNT_W-1:0]        area_r;
  logic [AREA_CNT_W-1:0]        ne_r, nm_r;
  logic [VCNT_W-1:0]            vcount_r;
  logic [VCNT_W-1:0]            edge_i;
  logic signed [WN_W-1:0]       wn;
  status_t                      res_status;
  logic [AREA_W-1:0]            res_hit;
  logic signed [WIND_W-1:0]     res_wind;

  logic [VCNT_W-1:0] area_cnt [CNT_DEPTH];
  vertex_t           vmem [VSTORE_DEPTH];

  logic mem_we, cnt_we, issue, load_out;
  logic [AREA_CNT_W-1:0] lim;
  logic [VCNT_W-1:0]     cur_cnt;
  logic [VCNT_W-1:0]     edge_nx;
  logic                  area_end, last_edge, pipe_empty, found;
  logic [VADDR_W-1:0]    addr_a, addr_b;
  logic [AREA_CNT_W-1:0] ne_sat, nm_sat;
  logic signed [31:0]    wn_ext;
  logic signed [WIND_W-1:0] wn_sat;

  // edge pipeline
  logic    v1, v2, v3;
  vertex_t rd_a, rd_b;
  logic signed [DIFF_W-1:0] da, db, dc, dd;
  logic [COORD_BITS-1:0] ma, mb, mc, md;
  logic na, nb, nc, nd, up2, down2;
  logic [PROD_W-1:0] m1, m2;
  logic n1x, n2x, up3, down3;
  logic n1, n2, s_pos, s_neg;
  logic signed [WN_W-1:0] delta;

  // current area
  assign lim       = (kind_r == KIND_EXCL) ? ne_r : nm_r;
  assign cur_cnt   = area_cnt[cidx_of(kind_r, area_r[AREA_W-1:0])];
  assign area_end  = (area_r >= lim) || (cur_cnt < VCNT_W'(MIN_VERTICES));
  assign last_edge = (edge_i == vcount_r - 1'b1);
  assign edge_nx   = (edge_i + 1'b1 < vcount_r) ? edge_i + 1'b1 : '0;
  assign addr_a    = vaddr_of(kind_r, area_r[AREA_W-1:0], edge_i[VTX_W-1:0]);
  assign addr_b    = vaddr_of(kind_r, area_r[AREA_W-1:0], edge_nx[VTX_W-1:0]);
  assign pipe_empty = !v1 && !v2 && !v3;
  assign found     = (wn != '0);

  assign ne_sat = (32'(cfg.excl_count) > MAX_AREAS) ? AREA_CNT_W'(MAX_AREAS)
                                                    : AREA_CNT_W'(cfg.excl_count);
  assign nm_sat = (32'(cfg.main_count) > MAX_AREAS) ? AREA_CNT_W'(MAX_AREAS)
                                                    : AREA_CNT_W'(cfg.main_count);

  assign wn_ext = 32'(wn);
  assign wn_sat = (wn_ext > WIND_MAX) ? WIND_W'(WIND_MAX) :
                  (wn_ext < WIND_MIN) ? WIND_W'(WIND_MIN) : WIND_W'(wn_ext);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (!q_empty && cmd.op == OP_QUERY) state_next = BK_AREA;
      end
      BK_AREA: begin
        if (area_end) begin
          state_next = (kind_r == KIND_EXCL) ? BK_AREA : BK_DONE;
        end else begin
          state_next = BK_EDGE;
        end
      end
      BK_EDGE: begin
        if (last_edge) state_next = BK_DRAIN;
      end
      BK_DRAIN: begin
        if (pipe_empty) state_next = found ? BK_DONE : BK_AREA;
      end
      BK_DONE: begin
        if (!out_valid || out_ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop      = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE:  pop      = !q_empty;
      BK_EDGE:  issue    = 1'b1;
      BK_DONE:  load_out = !out_valid || out_ready;
      default: begin
        pop      = 1'b0;
        issue    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign mem_we = pop && (cmd.op == OP_VWRITE);
  assign cnt_we = pop && (cmd.op == OP_CWRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CNT_DEPTH; k++) area_cnt[k] <= '0;
    end else if (cnt_we) begin
      area_cnt[cmd.cidx] <= cmd.cnt;
    end
  end

  // vertex store, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[cmd.vaddr] <= '{x: cmd.x, y: cmd.y};
    end
    if (issue) begin
      rd_a <= vmem[addr_a];
      rd_b <= vmem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop && cmd.op == OP_QUERY) begin
          qx         <= cmd.x;
          qy         <= cmd.y;
          kind_r     <= KIND_EXCL;
          area_r     <= '0;
          ne_r       <= ne_sat;
          nm_r       <= nm_sat;
          res_status <= ST_OUTSIDE;
          res_hit    <= '0;
          res_wind   <= '0;
        end
      end
      BK_AREA: begin
        if (area_end && kind_r == KIND_EXCL) begin
          kind_r <= KIND_MAIN;
          area_r <= '0;
        end else if (area_end) begin
          if (cfg.wired_en) res_status <= ST_WIRED;
        end else begin
          vcount_r <= cur_cnt;
          edge_i   <= '0;
        end
      end
      BK_EDGE: begin
        edge_i <= edge_i + 1'b1;
      end
      BK_DRAIN: begin
        if (pipe_empty) begin
          if (found) begin
            res_hit <= area_r[AREA_W-1:0];
            if (kind_r == KIND_EXCL) begin
              res_status <= ST_EXCL;
            end else begin
              res_status <= ST_MAIN;
              res_wind   <= wn_sat;
            end
          end else begin
            area_r <= area_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // stage 2: differences, magnitudes and crossing direction
  always_comb begin
    da = DIFF_W'(rd_b.x) - DIFF_W'(rd_a.x);
    db = DIFF_W'(qy)     - DIFF_W'(rd_a.y);
    dc = DIFF_W'(qx)     - DIFF_W'(rd_a.x);
    dd = DIFF_W'(rd_b.y) - DIFF_W'(rd_a.y);
  end

  always_ff @(posedge clk) begin
    ma    <= mag_of(da);
    mb    <= mag_of(db);
    mc    <= mag_of(dc);
    md    <= mag_of(dd);
    na    <= da[DIFF_W-1];
    nb    <= db[DIFF_W-1];
    nc    <= dc[DIFF_W-1];
    nd    <= dd[DIFF_W-1];
    up2   <= (rd_a.y <= qy) && (rd_b.y > qy);
    down2 <= (rd_a.y > qy) && (rd_b.y <= qy);
  end

  // stage 3: the two magnitude products
  always_ff @(posedge clk) begin
    m1    <= PROD_W'(ma) * PROD_W'(mb);
    m2    <= PROD_W'(mc) * PROD_W'(md);
    n1x   <= na ^ nb;
    n2x   <= nc ^ nd;
    up3   <= up2;
    down3 <= down2;
  end

  // stage 4: sign of the cross product, then accumulate
  always_comb begin
    n1 = (m1 != '0) && n1x;
    n2 = (m2 != '0) && n2x;
    if (!n1 && n2) begin
      s_pos = 1'b1;
      s_neg = 1'b0;
    end else if (n1 && !n2) begin
      s_pos = 1'b0;
      s_neg = 1'b1;
    end else if (!n1) begin
      s_pos = m1 > m2;
      s_neg = m1 < m2;
    end else begin
      s_pos = m1 < m2;
      s_neg = m1 > m2;
    end
    if (up3 && s_pos) begin
      delta = WN_W'(1);
    end else if (down3 && s_neg) begin
      delta = -WN_W'(1);
    end else begin
      delta = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_AREA) begin
      wn <= '0;
    end else if (v3) begin
      wn <= wn + delta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      winding  <= res_wind;
      status   <= res_status;
      hit_area <= HIT_W'(res_hit);
    end
  end

endmodule

// ----- src/zpip_checker.sv -----
// Port-level checks for the zoned point-in-polygon block, bound to the top level.
module zpip_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [zpip_pkg::WIND_W-1:0]     winding,
  input logic [zpip_pkg::STATUS_W-1:0]          status,
  input logic [zpip_pkg::HIT_W-1:0]             hit_area
);
  import zpip_pkg::*;

  // a pending result transaction holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(winding) && $stable(status)
                                && $stable(hit_area))
    else $error("result changed while stalled");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_wind_only_main: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OUTSIDE || status == ST_EXCL || status == ST_WIRED)
    |-> winding == '0)
    else $error("nonzero winding outside a main area");

  a_main_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MAIN |-> winding != '0)
    else $error("main hit with zero winding");

  a_hit_when_outside: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OUTSIDE || status == ST_WIRED) |-> hit_area == '0)
    else $error("hit area set for an outside point");

endmodule

bind zoned_point_in_polygon zpip_checker u_zpip_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .winding   (winding),
  .status    (status),
  .hit_area  (hit_area)
);

// ----- sim/tb_zoned_point_in_polygon.sv -----
// Testbench for zoned_point_in_polygon: directed and random polygon/query traffic with a scoreboard.
module tb_zoned_point_in_polygon;
  timeunit 1ns;
  timeprecision 1ps;

  import zpip_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 20;
  localparam int NUM_PHASES    = 8;
  localparam int MIXED_ITEMS   = 75;
  localparam int GAP_CAP       = 40;
  localparam int TIMEOUT_NS    = 30_000_000;
  localparam longint HUGE_SPAN = 1_500_000_000;
  localparam longint COORD_LO  = -64'sd2147483648;
  localparam longint COORD_HI  = 64'sd2147483647;
  localparam logic signed [COORD_BITS-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_BITS-1:0] C_MAX = 32'sh7fff_ffff;

  class zone_scoreboard;
    typedef struct {
      logic signed [WIND_W-1:0] winding;
      status_t                  status;
      logic [HIT_W-1:0]         hit;
    } zone_result_t;

    logic signed [COORD_BITS-1:0] vert_x[VSTORE_DEPTH];
    logic signed [COORD_BITS-1:0] vert_y[VSTORE_DEPTH];
    int           area_len[CNT_DEPTH];
    int           main_areas;
    int           excl_areas;
    bit           wired_en;
    zone_result_t expected_q[$];
    int           errors;

    function new();
      foreach (vert_x[i]) begin
        vert_x[i] = '0;
        vert_y[i] = '0;
      end
      foreach (area_len[i]) area_len[i] = 0;
      main_areas = 0;
      excl_areas = 0;
      wired_en   = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAIN_COUNT: main_areas = int'(data);
        CFG_EXCL_COUNT: excl_areas = int'(data);
        CFG_WIRED_EN:   wired_en = data[0];
        default: ;
      endcase
    endfunction

    // winding number of one stored polygon; products are kept exact at 70 bits
    function int area_winding(int base, int n, logic signed [COORD_BITS-1:0] px,
                              logic signed [COORD_BITS-1:0] py);
      logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
      logic signed [69:0] ex, ey, qx, qy, cr;
      int wn, i, nx;
      wn = 0;
      for (i = 0; i < n; i++) begin
        nx = (i + 1 < n) ? i + 1 : 0;
        x0 = vert_x[base + i];
        y0 = vert_y[base + i];
        x1 = vert_x[base + nx];
        y1 = vert_y[base + nx];
        ex = x1 - x0;
        ey = y1 - y0;
        qx = px - x0;
        qy = py - y0;
        cr = ex * qy - qx * ey;
        if (y0 <= py) begin
          if (y1 > py && cr > 0) wn++;
        end else if (y1 <= py && cr < 0) begin
          wn--;
        end
      end
      return wn;
    endfunction

    function zone_result_t predict(logic signed [COORD_BITS-1:0] px,
                                   logic signed [COORD_BITS-1:0] py);
      zone_result_t r;
      int ne, nm, j, n, w;
      bit decided;
      r.winding = '0;
      r.status  = ST_OUTSIDE;
      r.hit     = '0;
      decided   = 1'b0;
      ne = (excl_areas > MAX_AREAS) ? MAX_AREAS : excl_areas;
      nm = (main_areas > MAX_AREAS) ? MAX_AREAS : main_areas;
      for (j = 0; j < ne && !decided; j++) begin
        n = area_len[MAX_AREAS + j];
        if (n < MIN_VERTICES) break;
        if (area_winding((MAX_AREAS + j) * MAX_VERTICES, n, px, py) != 0) begin
          r.status = ST_EXCL;
          r.hit    = HIT_W'(j);
          decided  = 1'b1;
        end
      end
      for (j = 0; j < nm && !decided; j++) begin
        n = area_len[j];
        if (n < MIN_VERTICES) break;
        w = area_winding(j * MAX_VERTICES, n, px, py);
        if (w != 0) begin
          if (w > WIND_MAX) w = WIND_MAX;
          if (w < WIND_MIN) w = WIND_MIN;
          r.status  = ST_MAIN;
          r.hit     = HIT_W'(j);
          r.winding = WIND_W'(w);
          decided   = 1'b1;
        end
      end
      if (!decided && wired_en) r.status = ST_WIRED;
      return r;
    endfunction

    function void note_input(logic [REQ_W-1:0] req, logic kind, logic [IN_AREA_W-1:0] area,
                             logic [IN_VTX_W-1:0] vtx, logic [IN_CNT_W-1:0] cnt,
                             logic signed [COORD_BITS-1:0] x,
                             logic signed [COORD_BITS-1:0] y);
      int addr;
      case (req)
        REQ_VERTEX: begin
          if (int'(area) < MAX_AREAS && int'(vtx) < MAX_VERTICES) begin
            addr = int'(kind) * KIND_SLOTS + int'(area) * MAX_VERTICES + int'(vtx);
            vert_x[addr] = x;
            vert_y[addr] = y;
          end
        end
        REQ_COUNT: begin
          if (int'(area) < MAX_AREAS)
            area_len[int'(kind) * MAX_AREAS + int'(area)] =
              (int'(cnt) > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);
        end
        REQ_QUERY: expected_q.push_back(predict(x, y));
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [WIND_W-1:0] w, logic [STATUS_W-1:0] s,
                               logic [HIT_W-1:0] h);
      zone_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no query pending: winding %0d status %0d hit_area %0d",
                 $time, w, s, h);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (w !== e.winding) begin
        $display("%0t: winding mismatch: expected %0d, actual %0d", $time, e.winding, w);
        errors++;
      end
      if (s !== e.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, s);
        errors++;
      end
      if (h !== e.hit) begin
        $display("%0t: hit_area mismatch: expected %0d, actual %0d", $time, e.hit, h);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [REQ_W-1:0]               req_type;
  logic                           area_kind;
  logic [IN_AREA_W-1:0]           area_index;
  logic [IN_VTX_W-1:0]            vertex_index;
  logic [IN_CNT_W-1:0]            vertex_count;
  logic signed [IN_COORD_W-1:0]   coord_x;
  logic signed [IN_COORD_W-1:0]   coord_y;
  logic                           out_valid;
  logic                           out_ready = 1'b1;
  logic signed [WIND_W-1:0]       winding;
  logic [STATUS_W-1:0]            status;
  logic [HIT_W-1:0]               hit_area;
  logic                           cfg_write_en;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [CFG_DATA_W-1:0]          cfg_data;

  zone_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // stimulus-side view of the vertex store, used to keep every count backed by written vertices
  logic signed [COORD_BITS-1:0] gen_x[VSTORE_DEPTH];
  logic signed [COORD_BITS-1:0] gen_y[VSTORE_DEPTH];
  bit                           gen_written[VSTORE_DEPTH];
  longint                       ctr_x[CNT_DEPTH];
  longint                       ctr_y[CNT_DEPTH];
  longint                       span_r[CNT_DEPTH];

  zoned_point_in_polygon i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .area_kind    (area_kind),
    .area_index   (area_index),
    .vertex_index (vertex_index),
    .vertex_count (vertex_count),
    .coord_x      (coord_x),
    .coord_y      (coord_y),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .winding      (winding),
    .status       (status),
    .hit_area     (hit_area),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(winding, status, hit_area);
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
    if (v < COORD_LO) v = COORD_LO;
    if (v > COORD_HI) v = COORD_HI;
    return COORD_BITS'(v);
  endfunction

  function automatic logic signed [COORD_BITS-1:0] near_coord(longint c, longint s);
    return clamp_coord(c + longint'($urandom_range(32'(2 * s))) - s);
  endfunction

  function automatic int prefix_of(int slot);
    int k;
    k = 0;
    while (k < MAX_VERTICES && gen_written[slot * MAX_VERTICES + k]) k++;
    return k;
  endfunction

  function automatic int idle_gap();
    int g;
    g = 0;
    while (g < GAP_CAP && $urandom_range(99) < send_idle_pct) g++;
    return g;
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(input logic [REQ_W-1:0] req, input logic kind,
                           input logic [IN_AREA_W-1:0] area, input logic [IN_VTX_W-1:0] vtx,
                           input logic [IN_CNT_W-1:0] cnt,
                           input logic signed [COORD_BITS-1:0] x,
                           input logic signed [COORD_BITS-1:0] y);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type     = req;
    area_kind    = kind;
    area_index   = area;
    vertex_index = vtx;
    vertex_count = cnt;
    coord_x      = x;
    coord_y      = y;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(req, kind, area, vtx, cnt, x, y);
    @(negedge clk);
  endtask

  task automatic put_vertex(input int slot, input int k, input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y);
    gen_x[slot * MAX_VERTICES + k]       = x;
    gen_y[slot * MAX_VERTICES + k]       = y;
    gen_written[slot * MAX_VERTICES + k] = 1'b1;
    send_item(REQ_VERTEX, slot >= MAX_AREAS, IN_AREA_W'(slot % MAX_AREAS), IN_VTX_W'(k),
              IN_CNT_W'($urandom), x, y);
  endtask

  task automatic put_count(input int slot, input int n);
    send_item(REQ_COUNT, slot >= MAX_AREAS, IN_AREA_W'(slot % MAX_AREAS),
              IN_VTX_W'($urandom), IN_CNT_W'(n), $urandom, $urandom);
  endtask

  task automatic ask(input logic signed [COORD_BITS-1:0] x,
                     input logic signed [COORD_BITS-1:0] y);
    send_item(REQ_QUERY, 1'($urandom), IN_AREA_W'($urandom), IN_VTX_W'($urandom),
              IN_CNT_W'($urandom), x, y);
  endtask

  task automatic noise_item();
    send_item(REQ_QUERY + 2'd1, 1'($urandom), IN_AREA_W'($urandom), IN_VTX_W'($urandom),
              IN_CNT_W'($urandom), $urandom, $urandom);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg_port(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_write_en = 1'b1;
    cfg_index    = idx;
    cfg_data     = CFG_DATA_W'(data);
    @(posedge clk);
    sb.write_reg(idx, CFG_DATA_W'(data));
    @(negedge clk);
  endtask

  task automatic set_config(input int m, input int e, input int w);
    write_reg_port(CFG_MAIN_COUNT, m);
    write_reg_port(CFG_EXCL_COUNT, e);
    write_reg_port(CFG_WIRED_EN, w);
    cfg_write_en = 1'b0;
  endtask

  // shapes: random points (self-crossing), square loop ccw, square loop cw, double loop
  task automatic build_area(input int slot, input int n);
    longint r, per, p, off, vx, vy;
    int k, kk, shape, loops;
    if ($urandom_range(9) == 0) begin
      ctr_x[slot]  = 0;
      ctr_y[slot]  = 0;
      span_r[slot] = HUGE_SPAN;
    end else begin
      ctr_x[slot]  = near_coord(0, 3000);
      ctr_y[slot]  = near_coord(0, 3000);
      span_r[slot] = $urandom_range(4000, 300);
    end
    r     = span_r[slot];
    per   = 8 * r;
    shape = $urandom_range(3);
    loops = (shape == 3) ? 2 : 1;
    for (k = 0; k < n; k++) begin
      if (shape == 0) begin
        put_vertex(slot, k, near_coord(ctr_x[slot], r), near_coord(ctr_y[slot], r));
      end else begin
        kk  = (shape == 2) ? n - 1 - k : k;
        p   = (longint'(kk) * per * loops / n) % per;
        off = p % (2 * r);
        case (p / (2 * r))
          0: begin vx = ctr_x[slot] - r + off; vy = ctr_y[slot] - r; end
          1: begin vx = ctr_x[slot] + r; vy = ctr_y[slot] - r + off; end
          2: begin vx = ctr_x[slot] + r - off; vy = ctr_y[slot] + r; end
          default: begin vx = ctr_x[slot] - r; vy = ctr_y[slot] + r - off; end
        endcase
        put_vertex(slot, k, clamp_coord(vx), clamp_coord(vy));
      end
    end
    put_count(slot, (n == MAX_VERTICES) ? $urandom_range(127, MAX_VERTICES) : n);
  endtask

  task automatic mixed_item();
    int sel, t, pre, k, n;
    sel = $urandom_range(99);
    t   = $urandom_range(CNT_DEPTH - 1);
    pre = prefix_of(t);
    if (sel < 55) begin
      if ($urandom_range(7) == 0 && pre > 0) begin
        // land exactly on a stored vertex
        k = $urandom_range(pre - 1);
        ask(gen_x[t * MAX_VERTICES + k], gen_y[t * MAX_VERTICES + k]);
      end else begin
        ask(near_coord(ctr_x[t], span_r[t] * 5 / 4), near_coord(ctr_y[t], span_r[t] * 5 / 4));
      end
    end else if (sel < 63) begin
      ask($urandom, $urandom);
    end else if (sel < 78) begin
      k = $urandom_range((pre < MAX_VERTICES) ? pre : MAX_VERTICES - 1);
      put_vertex(t, k, near_coord(ctr_x[t], span_r[t]), near_coord(ctr_y[t], span_r[t]));
    end else if (sel < 92) begin
      // never let a count of at least MIN_VERTICES, once saturated, point past the written prefix
      if ($urandom_range(4) == 0 || pre < MIN_VERTICES) n = $urandom_range(MIN_VERTICES - 1);
      else if (pre == MAX_VERTICES) n = $urandom_range(127, MIN_VERTICES);
      else n = $urandom_range(pre, MIN_VERTICES);
      put_count(t, n);
    end else begin
      noise_item();
    end
  endtask

  initial begin
    int p, s, i;
    int main_tbl[NUM_PHASES];
    int excl_tbl[NUM_PHASES];
    main_tbl = '{4, 7, 2, 0, 3, 4, 1, 6};
    excl_tbl = '{0, 4, 1, 7, 2, 3, 0, 5};
    sb = new();
    foreach (gen_written[j]) begin
      gen_written[j] = 1'b0;
      gen_x[j]       = '0;
      gen_y[j]       = '0;
    end
    foreach (ctr_x[j]) begin
      ctr_x[j]  = 0;
      ctr_y[j]  = 0;
      span_r[j] = 1000;
    end
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = REQ_VERTEX;
    area_kind    = KIND_MAIN;
    area_index   = '0;
    vertex_index = '0;
    vertex_count = '0;
    coord_x      = '0;
    coord_y      = '0;
    cfg_write_en = 1'b0;
    cfg_index    = CFG_MAIN_COUNT;
    cfg_data     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // directed: reset config, unknown request, extreme square, exclusion hit, short area
    ask(0, 0);
    noise_item();
    wait_idle();
    set_config(MAX_AREAS, 0, 1);
    ask(C_MIN, C_MAX);
    put_vertex(0, 0, C_MIN, C_MIN);
    put_vertex(0, 1, C_MAX, C_MIN);
    put_vertex(0, 2, C_MAX, C_MAX);
    put_vertex(0, 3, C_MIN, C_MAX);
    put_count(0, 4);
    ask(0, 0);
    ask(C_MIN, C_MIN);
    ask(C_MAX, 0);
    put_vertex(MAX_AREAS, 0, -10, -10);
    put_vertex(MAX_AREAS, 1, 10, -10);
    put_vertex(MAX_AREAS, 2, 0, 10);
    put_count(MAX_AREAS, 3);
    wait_idle();
    set_config(MAX_AREAS, 1, 0);
    ask(0, 0);
    ask(1000, 1000);
    put_count(0, 2);
    ask(1000, 1000);
    put_count(0, 4);
    ask(-1_000_000, 5);
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      set_config(main_tbl[p], excl_tbl[p], (p % 3 == 0) ? 1 : 0);
      for (s = 0; s < CNT_DEPTH; s++) begin
        if (p == 0)
          build_area(s, (s == 1) ? MAX_VERTICES : $urandom_range(10, MIN_VERTICES));
        else if ($urandom_range(2) == 0)
          build_area(s, ($urandom_range(11) == 0) ? MAX_VERTICES
                                                  : $urandom_range(10, MIN_VERTICES));
      end
      for (i = 0; i < MIXED_ITEMS; i++) mixed_item();
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- zoned_point_in_polygon.f -----
src/zpip_pkg.sv
src/zpip_front.sv
src/zpip_queue.sv
src/zpip_back.sv
src/zoned_point_in_polygon.sv
src/zpip_checker.sv
sim/tb_zoned_point_in_polygon.sv
